[hdl/kts_pkg.sv]
package kts_pkg;

    localparam int FRAC_BITS = 24;
    localparam int CHI_WIDTH = 16;

    localparam logic [63:0] COV_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MIN = -SUM_MAX;
    localparam logic [CHI_WIDTH-1:0] CHI_SAT = '1;

    // Register indexes on the configuration port (byte address 8*index)
    localparam logic [2:0] REG_SPACING = 3'd0;
    localparam logic [2:0] REG_INV     = 3'd1;
    localparam logic [2:0] REG_MEAS    = 3'd2;
    localparam logic [2:0] REG_SCAT    = 3'd3;
    localparam logic [2:0] REG_CUT     = 3'd4;

    localparam logic OP_SEED   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Saturating add clamped to +-(2^63-1)
    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > SUM_MAX) begin
            s = SUM_MAX;
        end else if (s < SUM_MIN) begin
            s = SUM_MIN;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] signed_sat(input logic neg,
                                                      input logic [63:0] m);
        logic [63:0] v;
        v = m[63] ? COV_MAX : m;
        return neg ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x[63] ? (~x + 64'd1) : x;
    endfunction

endpackage

[hdl/kalman_track_step.sv]
// A seed, or an update whose denominator is not positive, finishes without dividing; a full
// update divides. A saturated divide skips the quotient loop.
// Input is held off while busy and while a finished item waits for the output register.
// One 32x32 multiplier used four times per product and a restoring divider that retires
// one quotient bit a cycle do all the arithmetic.
// Reset (aresetn low at a clock edge) clears track state and restores register defaults.
module kalman_track_step #(
    parameter int COORD_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: hit_z [31:0], prev_hit_z [63:32]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,
    // s_tuser: op [0]
    input  logic [0:0]  s_tuser,
    // m_tdata: track_position [31:0], track_slope [63:32], chi_squared [79:64],
    //          accepted [80], zero fill [87:81]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import kts_pkg::*;

    localparam logic signed [63:0] CRD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] CRD_MIN = -CRD_MAX - 64'sd1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOAD, ST_MUL, ST_DSET, ST_DIV, ST_FIN, ST_OUT
    } state_t;

    // Arithmetic steps of one item; each is one product, optionally divided
    typedef enum logic [3:0] {
        SP_SEED_SLOPE, SP_SEED_CROSS, SP_SEED_SVAR,
        SP_BP, SP_AP, SP_PP,
        SP_POS, SP_SLP, SP_A, SP_B, SP_C, SP_CHI
    } step_t;

    function automatic logic [COORD_WIDTH-1:0] sat_coord(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > CRD_MAX) ? CRD_MAX : ((v < CRD_MIN) ? CRD_MIN : v);
        return c[COORD_WIDTH-1:0];
    endfunction

    function automatic logic signed [63:0] crd64(input logic [COORD_WIDTH-1:0] c);
        return {{(64 - COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
    endfunction

    // Configuration registers
    logic [30:0] spacing_reg;
    logic [30:0] inv_reg;
    logic [40:0] meas_reg;
    logic [40:0] scat_reg;
    logic [15:0] cut_reg;

    // Track state
    logic [COORD_WIDTH-1:0] position_reg;
    logic [COORD_WIDTH-1:0] slope_reg;
    logic signed [63:0] cov_pos_reg;
    logic signed [63:0] cov_cross_reg;
    logic signed [63:0] cov_slope_reg;

    // Per-item working values
    state_t state_reg;
    step_t  step_reg;
    logic signed [63:0] hit_reg;
    logic signed [63:0] diff_reg;
    logic signed [63:0] ap_reg;
    logic signed [63:0] bp_reg;
    logic signed [63:0] cq_reg;
    logic signed [63:0] pp_reg;
    logic signed [63:0] r_reg;
    logic signed [63:0] den_reg;
    logic [15:0]  chi_reg;

    // Shared multiply / divide unit
    logic [63:0]  mx_reg;
    logic [63:0]  my_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  lo_reg;
    logic [63:0]  quo_reg;
    logic [5:0]   cnt_reg;

    logic        m_tvalid_reg;
    logic [87:0] m_tdata_reg;

    logic signed [63:0] s2;
    logic signed [63:0] inv64;
    logic signed [63:0] d64;
    logic signed [63:0] q64;
    logic signed [63:0] cq_w;
    logic signed [63:0] opx;
    logic signed [63:0] opy;
    logic        is_div;
    logic [31:0] part_x;
    logic [31:0] part_y;
    logic [63:0] part_p;
    logic [127:0] part_sh;
    logic [63:0] div_hi;
    logic [63:0] div_lo;
    logic        div_sat;
    logic [64:0] rem_sh;
    logic        rem_ge;
    logic [63:0] q_raw;
    logic signed [63:0] t_val;
    logic signed [63:0] pp_w;
    logic signed [63:0] r_w;
    logic signed [63:0] den_w;
    logic signed [63:0] pos_ext;
    logic signed [63:0] slope_ext;
    logic        out_free;
    logic        cfg_wr;

    assign s2    = {23'd0, meas_reg};
    assign inv64 = {33'd0, inv_reg};
    assign d64   = {33'd0, spacing_reg};
    assign q64   = {23'd0, scat_reg};
    assign cq_w  = sat_add(cov_slope_reg, q64);
    assign is_div = (step_reg inside {SP_POS, SP_SLP, SP_A, SP_B, SP_C, SP_CHI});

    // Operand selection per step
    always_comb begin
        opx = d64;
        opy = d64;
        case (step_reg)
            SP_SEED_SLOPE: begin opx = diff_reg;                             opy = inv64;  end
            SP_SEED_CROSS: begin opx = s2;                                   opy = inv64;  end
            SP_SEED_SVAR:  begin opx = sat_add(cov_cross_reg, cov_cross_reg); opy = inv64; end
            SP_BP:         begin opx = d64;                                  opy = cq_w;   end
            SP_AP:         begin opx = d64; opy = sat_add(cov_cross_reg, bp_reg);          end
            SP_PP:         begin opx = d64;                       opy = crd64(slope_reg);  end
            SP_POS:        begin opx = ap_reg;                               opy = r_reg;  end
            SP_SLP:        begin opx = bp_reg;                               opy = r_reg;  end
            SP_A:          begin opx = ap_reg;                               opy = ap_reg; end
            SP_B:          begin opx = ap_reg;                               opy = bp_reg; end
            SP_C:          begin opx = bp_reg;                               opy = bp_reg; end
            SP_CHI:        begin opx = r_reg;                                opy = r_reg;  end
            default:       begin opx = d64;                                  opy = d64;    end
        endcase
    end

    // One 32x32 partial product per cycle, accumulated at its offset
    assign part_x = cnt_reg[1] ? mx_reg[63:32] : mx_reg[31:0];
    assign part_y = cnt_reg[0] ? my_reg[63:32] : my_reg[31:0];
    assign part_p = part_x * part_y;
    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    part_sh = {64'd0, part_p};
            2'd3:    part_sh = {part_p, 64'd0};
            default: part_sh = {32'd0, part_p, 32'd0};
        endcase
    end

    // Dividend setup: chi-squared divides r*r scaled by 2^8
    always_comb begin
        if (step_reg == SP_CHI) begin
            div_hi  = acc_reg[119:56];
            div_lo  = {acc_reg[55:0], 8'd0};
            div_sat = (acc_reg[127:120] != 8'd0) || (acc_reg[119:56] >= den_reg);
        end else begin
            div_hi  = acc_reg[127:64];
            div_lo  = acc_reg[63:0];
            div_sat = (acc_reg[127:64] >= den_reg);
        end
    end

    // Restoring division step, one quotient bit a cycle
    assign rem_sh = {rem_reg, lo_reg[63]};
    assign rem_ge = rem_sh >= {1'b0, den_reg};

    // Finished product: shift by the fraction bits or take the quotient
    assign q_raw = is_div ? quo_reg
                 : ((acc_reg[127:88] != 40'd0) ? COV_MAX : acc_reg[87:24]);
    assign t_val = signed_sat(neg_reg, q_raw);

    assign pp_w  = crd64(sat_coord(crd64(position_reg) + t_val));
    assign r_w   = hit_reg - pp_w;
    assign den_w = sat_add(s2, ap_reg);

    assign pos_ext   = crd64(position_reg);
    assign slope_ext = crd64(slope_reg);

    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_wr   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= SP_SEED_SLOPE;
            m_tvalid_reg  <= 1'b0;
            spacing_reg   <= 31'd167772160;
            inv_reg       <= 31'd1677722;
            meas_reg      <= 41'd101331000;
            scat_reg      <= 41'd4503600000;
            cut_reg       <= 16'd2048;
            position_reg  <= '0;
            slope_reg     <= '0;
            cov_pos_reg   <= '0;
            cov_cross_reg <= '0;
            cov_slope_reg <= '0;
        end else begin
            // Load a finished item into the output register, or drop the one taken
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_wr) begin
                case (paddr[5:3])
                    REG_SPACING: spacing_reg <= pwdata[30:0];
                    REG_INV:     inv_reg     <= pwdata[30:0];
                    REG_MEAS:    meas_reg    <= pwdata[40:0];
                    REG_SCAT:    scat_reg    <= pwdata[40:0];
                    REG_CUT:     cut_reg     <= pwdata[15:0];
                    default:     ;
                endcase
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        hit_reg  <= {{32{s_tdata[31]}}, s_tdata[31:0]};
                        diff_reg <= {{32{s_tdata[31]}}, s_tdata[31:0]}
                                  - {{32{s_tdata[63]}}, s_tdata[63:32]};
                        chi_reg  <= '0;
                        if (s_tuser[0] == OP_SEED) begin
                            // Seed: position and position variance are set at once
                            position_reg <= sat_coord({{32{s_tdata[31]}}, s_tdata[31:0]});
                            cov_pos_reg  <= s2;
                            step_reg     <= SP_SEED_SLOPE;
                        end else begin
                            step_reg <= SP_BP;
                        end
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    if (step_reg == SP_BP) begin
                        cq_reg <= cq_w;
                    end
                    mx_reg    <= mag(opx);
                    my_reg    <= mag(opy);
                    neg_reg   <= opx[63] != opy[63];
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    acc_reg <= acc_reg + part_sh;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg[1:0] == 2'd3) begin
                        state_reg <= is_div ? ST_DSET : ST_FIN;
                    end
                end
                ST_DSET: begin
                    if (div_sat) begin
                        quo_reg   <= '1;
                        state_reg <= ST_FIN;
                    end else begin
                        rem_reg   <= div_hi;
                        lo_reg    <= div_lo;
                        quo_reg   <= '0;
                        cnt_reg   <= 6'd63;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    lo_reg <= {lo_reg[62:0], 1'b0};
                    if (rem_sh[64] || rem_ge) begin
                        rem_reg <= 64'(rem_sh - {1'b0, den_reg});
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    case (step_reg)
                        SP_SEED_SLOPE: begin
                            slope_reg <= sat_coord(t_val);
                            step_reg  <= SP_SEED_CROSS;
                            state_reg <= ST_LOAD;
                        end
                        SP_SEED_CROSS: begin
                            cov_cross_reg <= t_val;
                            step_reg      <= SP_SEED_SVAR;
                            state_reg     <= ST_LOAD;
                        end
                        SP_SEED_SVAR: begin
                            cov_slope_reg <= t_val;
                            state_reg     <= ST_OUT;
                        end
                        SP_BP: begin
                            bp_reg    <= sat_add(cov_cross_reg, t_val);
                            step_reg  <= SP_AP;
                            state_reg <= ST_LOAD;
                        end
                        SP_AP: begin
                            ap_reg    <= sat_add(cov_pos_reg, t_val);
                            step_reg  <= SP_PP;
                            state_reg <= ST_LOAD;
                        end
                        SP_PP: begin
                            pp_reg  <= pp_w;
                            r_reg   <= r_w;
                            den_reg <= den_w;
                            if (den_w <= 64'sd0) begin
                                // No usable denominator: keep the prediction
                                position_reg  <= pp_w[COORD_WIDTH-1:0];
                                cov_pos_reg   <= ap_reg;
                                cov_cross_reg <= bp_reg;
                                cov_slope_reg <= cq_reg;
                                chi_reg       <= (r_w == 64'sd0) ? 16'd0 : CHI_SAT;
                                state_reg     <= ST_OUT;
                            end else begin
                                step_reg  <= SP_POS;
                                state_reg <= ST_LOAD;
                            end
                        end
                        SP_POS: begin
                            position_reg <= sat_coord(pp_reg + t_val);
                            step_reg     <= SP_SLP;
                            state_reg    <= ST_LOAD;
                        end
                        SP_SLP: begin
                            slope_reg <= sat_coord(crd64(slope_reg) + t_val);
                            step_reg  <= SP_A;
                            state_reg <= ST_LOAD;
                        end
                        SP_A: begin
                            cov_pos_reg <= sat_add(ap_reg, -t_val);
                            step_reg    <= SP_B;
                            state_reg   <= ST_LOAD;
                        end
                        SP_B: begin
                            cov_cross_reg <= sat_add(bp_reg, -t_val);
                            step_reg      <= SP_C;
                            state_reg     <= ST_LOAD;
                        end
                        SP_C: begin
                            cov_slope_reg <= sat_add(cq_reg, -t_val);
                            step_reg      <= SP_CHI;
                            state_reg     <= ST_LOAD;
                        end
                        SP_CHI: begin
                            chi_reg   <= (quo_reg > 64'd65535) ? CHI_SAT : quo_reg[15:0];
                            state_reg <= ST_OUT;
                        end
                        default: state_reg <= ST_IDLE;
                    endcase
                end
                ST_OUT: begin
                    // Hold until the output register is free, then hand over the item
                    if (out_free) begin
                        m_tdata_reg <= {7'd0, (chi_reg <= cut_reg), chi_reg,
                                        slope_ext[31:0], pos_ext[31:0]};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SPACING: prdata = {33'd0, spacing_reg};
            REG_INV:     prdata = {33'd0, inv_reg};
            REG_MEAS:    prdata = {23'd0, meas_reg};
            REG_SCAT:    prdata = {23'd0, scat_reg};
            REG_CUT:     prdata = {48'd0, cut_reg};
            default:     prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[tb/sv/kalman_track_step_tb.sv]
module kalman_track_step_tb;
    import kts_pkg::*;

    typedef struct {
        logic        op;
        logic [31:0] hit;
        logic [31:0] prev;
    } hit_item_t;

    typedef struct {
        logic [31:0] position;
        logic [31:0] slope;
        logic [15:0] chi;
        logic        pass;
    } track_fit_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // s_tdata: hit_z [31:0], prev_hit_z [63:32]
    logic [63:0] s_tdata = '0;
    // s_tuser: op [0]
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // m_tdata: track_position [31:0], track_slope [63:32], chi_squared [79:64],
    //          accepted [80]
    logic [87:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    kalman_track_step uut (.*);

    always #5 aclk = ~aclk;

    // Shadow of the block's registers and track state
    logic [63:0] spacing_q = 64'd167772160;
    logic [63:0] inv_q = 64'd1677722;
    logic [63:0] meas_q = 64'd101331000;
    logic [63:0] scat_q = 64'd4503600000;
    logic [63:0] cut_q = 64'd2048;
    logic signed [63:0] trk_pos = 0, trk_slope = 0, cov_a = 0, cov_b = 0, cov_c = 0;

    hit_item_t  hits_to_send[$];
    track_fit_t fits_due[$];
    hit_item_t  cur_item;
    int         fail_count = 0;
    bit         long_stall_req = 0;

    function automatic logic [63:0] abs64(input logic signed [63:0] x);
        return x[63] ? 64'd0 - x : x;
    endfunction

    function automatic logic signed [63:0] clamp_mag(input bit neg, input logic [63:0] m);
        logic [63:0] v;
        v = m[63] ? COV_MAX : m;
        return neg ? -$signed(v) : $signed(v);
    endfunction

    function automatic logic signed [63:0] clamp_sum(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > SUM_MAX) s = SUM_MAX;
        else if (s < SUM_MIN) s = SUM_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] clamp_coord(input logic signed [64:0] v);
        if (v > 65'sd2147483647) return 64'sd2147483647;
        if (v < -65'sd2147483648) return -64'sd2147483648;
        return v[63:0];
    endfunction

    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] x,
                                                          input logic signed [63:0] y);
        logic [127:0] p;
        logic [63:0]  q;
        p = {64'd0, abs64(x)} * {64'd0, abs64(y)};
        q = (p[127:88] != 0) ? '1 : p[87:24];
        return clamp_mag(x[63] ^ y[63], q);
    endfunction

    function automatic logic [63:0] wide_quotient(input logic [127:0] p, input logic [63:0] den);
        logic [127:0] q;
        if (p[127:64] >= den) return '1;
        q = p / {64'd0, den};
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] ratio_product(input logic signed [63:0] x,
                                                         input logic signed [63:0] y,
                                                         input logic signed [63:0] den);
        logic [127:0] p;
        p = {64'd0, abs64(x)} * {64'd0, abs64(y)};
        return clamp_mag(x[63] ^ y[63], wide_quotient(p, den));
    endfunction

    // Advance the track state by one item and queue the fit it must produce
    function automatic void fit_track(input hit_item_t it);
        logic signed [63:0] hit, prev, cq, bp, ap, pp, r, den;
        logic [127:0] rr;
        logic [63:0]  cv;
        track_fit_t   f;
        hit = {{32{it.hit[31]}}, it.hit};
        prev = {{32{it.prev[31]}}, it.prev};
        f.chi = 16'd0;
        if (it.op == OP_SEED) begin
            trk_pos = clamp_coord(hit);
            trk_slope = clamp_coord(scaled_product(hit - prev, inv_q));
            cov_a = meas_q;
            cov_b = scaled_product(meas_q, inv_q);
            cov_c = scaled_product(clamp_sum(cov_b, cov_b), inv_q);
        end else begin
            cq = clamp_sum(cov_c, scat_q);
            bp = clamp_sum(cov_b, scaled_product(spacing_q, cq));
            ap = clamp_sum(cov_a, scaled_product(spacing_q, clamp_sum(cov_b, bp)));
            pp = clamp_coord($signed({trk_pos[63], trk_pos})
                             + scaled_product(spacing_q, trk_slope));
            r = hit - pp;
            den = clamp_sum(meas_q, ap);
            if (den <= 0) begin
                // degenerate gain: keep the prediction, flag any residual
                trk_pos = pp;
                cov_a = ap; cov_b = bp; cov_c = cq;
                f.chi = (r == 0) ? 16'd0 : CHI_SAT;
            end else begin
                trk_pos = clamp_coord(64'(pp + ratio_product(ap, r, den)));
                trk_slope = clamp_coord(64'(trk_slope + ratio_product(bp, r, den)));
                cov_a = clamp_sum(ap, -ratio_product(ap, ap, den));
                cov_b = clamp_sum(bp, -ratio_product(ap, bp, den));
                cov_c = clamp_sum(cq, -ratio_product(bp, bp, den));
                rr = {64'd0, abs64(r)} * {64'd0, abs64(r)};
                if (rr[127:120] != 0) begin
                    f.chi = CHI_SAT;
                end else begin
                    cv = wide_quotient(rr << 8, den);
                    f.chi = (cv > 64'd65535) ? CHI_SAT : cv[15:0];
                end
            end
        end
        f.position = trk_pos[31:0];
        f.slope = trk_slope[31:0];
        f.pass = ({48'd0, f.chi} <= cut_q);
        fits_due.insert(fits_due.size(), f);
    endfunction

    // Sender: bursts of random length separated by random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) fit_track(cur_item);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (hits_to_send.size() > 0) begin
                    cur_item = hits_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_item.prev, cur_item.hit};
                    s_tuser <= cur_item.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall density that shifts over time, plus one long hold
    int stall_pct = 0, pattern_left = 0, long_left = 0;
    track_fit_t want;
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (fits_due.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                fail_count++;
            end else begin
                want = fits_due.pop_front();
                if (m_tdata[31:0] !== want.position) begin
                    $error("track_position expected %h got %h", want.position, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.slope) begin
                    $error("track_slope expected %h got %h", want.slope, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[79:64] !== want.chi) begin
                    $error("chi_squared expected %0d got %0d", want.chi, m_tdata[79:64]);
                    fail_count++;
                end
                if (m_tdata[80] !== want.pass) begin
                    $error("accepted expected %b got %b", want.pass, m_tdata[80]);
                    fail_count++;
                end
            end
        end
        if (long_left > 0) begin
            long_left--;
            m_tready <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 0;
            long_left = 1500;
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(50, 400);
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 40;
                    default: stall_pct = 85;
                endcase
            end else begin
                pattern_left--;
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SPACING: spacing_q = value & 64'h7FFF_FFFF;
            REG_INV:     inv_q = value & 64'h7FFF_FFFF;
            REG_MEAS:    meas_q = value & 64'h1FF_FFFF_FFFF;
            REG_SCAT:    scat_q = value & 64'h1FF_FFFF_FFFF;
            default:     cut_q = value & 64'hFFFF;
        endcase
    endtask

    task automatic add_hit(input logic op, input logic [31:0] hit, input logic [31:0] prev);
        hit_item_t it;
        it.op = op; it.hit = hit; it.prev = prev;
        hits_to_send.insert(hits_to_send.size(), it);
    endtask

    // Hold until every queued item is in and every fit is out
    task automatic drain();
        while (hits_to_send.size() != 0 || s_tvalid || fits_due.size() != 0)
            @(posedge aclk);
    endtask

    // Queue a near-straight track: a seed, then updates along a line with noise
    task automatic add_track(input int n_updates);
        logic signed [31:0] z, step, noise;
        logic signed [63:0] slope_guess;
        z = $urandom;
        z = z >>> $urandom_range(0, 8);
        slope_guess = $signed($urandom_range(0, 32'h0080_0000)) - 64'sh0040_0000;
        step = 32'(scaled_product(slope_guess, spacing_q));
        add_hit(OP_SEED, z + step, z);
        z = z + step;
        for (int k = 0; k < n_updates; k++) begin
            noise = $signed($urandom_range(0, 32'h8000)) - 32'sh4000;
            if ($urandom_range(0, 19) == 0) noise = $urandom;
            z = z + step + noise;
            add_hit(OP_UPDATE, z, $urandom);
        end
    endtask

    task automatic random_config();
        write_reg(REG_SPACING, ($urandom_range(0, 3) == 0) ? {32'd0, $urandom}
                               : {32'd0, $urandom_range(1, 32'h1000_0000)});
        write_reg(REG_INV, ($urandom_range(0, 3) == 0) ? {32'd0, $urandom}
                           : {32'd0, $urandom_range(1, 32'h0400_0000)});
        write_reg(REG_MEAS, {$urandom, $urandom} >> $urandom_range(23, 40));
        write_reg(REG_SCAT, {$urandom, $urandom} >> $urandom_range(23, 40));
        write_reg(REG_CUT, {32'd0, $urandom_range(0, 16'hFFFF)});
    endtask

    initial begin
        int sent;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: update straight from reset, seeds at the field extremes
        add_hit(OP_UPDATE, 32'h0100_0000, 32'h0);
        add_hit(OP_SEED, 32'h7FFF_FFFF, 32'h8000_0000);
        add_hit(OP_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF);
        add_hit(OP_SEED, 32'h8000_0000, 32'h7FFF_FFFF);
        add_hit(OP_UPDATE, 32'h7FFF_FFFF, 32'h0);
        add_hit(OP_SEED, 32'h0, 32'h0);
        add_hit(OP_UPDATE, 32'h0000_1000, 32'h0);
        add_hit(OP_UPDATE, 32'h0000_0800, 32'h0);
        drain();

        // Zero variances: denominator drops to zero, with and without a residual
        write_reg(REG_MEAS, 64'd0);
        write_reg(REG_SCAT, 64'd0);
        write_reg(REG_CUT, 64'd0);
        add_hit(OP_SEED, 32'h0, 32'h0);
        add_hit(OP_UPDATE, 32'h0, 32'h0);
        add_hit(OP_UPDATE, 32'h0000_0005, 32'h0);
        add_hit(OP_UPDATE, 32'hFFFF_FFFF, 32'h0);
        drain();

        // Extremes of every register
        write_reg(REG_SPACING, 64'd1);
        write_reg(REG_INV, 64'hFFFF_FFFF);
        write_reg(REG_MEAS, 64'h1FF_FFFF_FFFF);
        write_reg(REG_SCAT, 64'h1FF_FFFF_FFFF);
        write_reg(REG_CUT, 64'hFFFF);
        add_hit(OP_SEED, 32'h1234_5678, 32'hEDCB_A987);
        add_hit(OP_UPDATE, 32'h8000_0000, 32'h0);
        add_hit(OP_UPDATE, 32'h7FFF_FFFF, 32'h0);
        drain();
        write_reg(REG_SPACING, 64'h7FFF_FFFF);
        write_reg(REG_INV, 64'd1);
        write_reg(REG_MEAS, 64'd1);
        write_reg(REG_SCAT, 64'd0);
        write_reg(REG_CUT, 64'd2048);
        add_hit(OP_SEED, 32'h0100_0000, 32'h0);
        add_hit(OP_UPDATE, 32'h0200_0000, 32'h0);
        add_hit(OP_UPDATE, 32'h7FFF_0000, 32'h0);
        drain();

        // Random: tracks under several register settings; hold the receiver once
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0) begin
                write_reg(REG_SPACING, 64'd167772160);
                write_reg(REG_INV, 64'd1677722);
                write_reg(REG_MEAS, 64'd101331000);
                write_reg(REG_SCAT, 64'd4503600000);
                write_reg(REG_CUT, 64'd2048);
            end else begin
                random_config();
            end
            sent = 0;
            while (sent < 215) begin
                if ($urandom_range(0, 9) == 0) begin
                    add_hit(1'($urandom_range(0, 1)), $urandom, $urandom);
                    sent++;
                end else begin
                    int n;
                    n = $urandom_range(1, 7);
                    add_track(n);
                    sent += n + 1;
                end
            end
            if (phase == 1) begin
                // seeds are quick, so the output register fills and input backs up
                for (int k = 0; k < 6; k++) add_hit(OP_SEED, $urandom, $urandom);
                long_stall_req = 1;
            end
            drain();
        end

        repeat (1000) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS kalman_track_step");
        end else begin
            $display("FAIL kalman_track_step");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("FAIL kalman_track_step");
        $finish;
    end

endmodule

[sim.f]
hdl/kts_pkg.sv
hdl/kalman_track_step.sv
tb/sv/kalman_track_step_tb.sv
